@@ design/kpc_pkg.sv @@
// Package for the key press classifier: phase and key codes, configuration
// and result structures. No dependencies.
`default_nettype none
package kpc_pkg;

	// Machine phases
	typedef enum logic [3:0] {
		PH_IDLE          = 4'd0,
		PH_SHORT_DEB     = 4'd1,
		PH_SHORT_REL     = 4'd2,
		PH_LONG_DEB      = 4'd3,
		PH_LONG_REL      = 4'd4,
		PH_LONG_HELD     = 4'd5,
		PH_LONG_HELD_REL = 4'd6,
		PH_REPEAT_CHK    = 4'd7,
		PH_REPEAT_DEB    = 4'd8,
		PH_REPEAT_REL    = 4'd9
	} phase_t;

	// Pending key codes
	typedef enum logic [1:0] {
		KEY_NONE   = 2'd0,
		KEY_MAGNET = 2'd1,
		KEY_TOUCH  = 2'd2
	} key_t;

	// Configuration register indexes
	localparam logic [3:0] REG_CHECK_TICKS   = 4'd0;
	localparam logic [3:0] REG_SHORT_COUNT   = 4'd1;
	localparam logic [3:0] REG_LONG_COUNT    = 4'd2;
	localparam logic [3:0] REG_REPEAT_COUNT  = 4'd3;
	localparam logic [3:0] REG_TOUCH_LIMIT   = 4'd4;
	localparam logic [3:0] REG_STUCK_TICKS   = 4'd5;
	localparam logic [3:0] REG_WINDOW_TICKS  = 4'd6;
	localparam logic [3:0] REG_PRESSED_LEVEL = 4'd7;

	// Event flag bits
	localparam int FLAG_SHORT  = 0;
	localparam int FLAG_LONG   = 1;
	localparam int FLAG_WINDOW = 2;
	localparam int FLAG_ERROR  = 3;

	localparam logic [15:0] TOUCH_CNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0] check_ticks;
		logic [7:0]  short_count;
		logic [7:0]  long_count;
		logic [7:0]  repeat_count;
		logic [15:0] touch_limit;
		logic [15:0] stuck_ticks;
		logic [15:0] window_ticks;
		logic        pressed_level;
	} cfg_t;

	typedef struct packed {
		logic       magnet_edge;
		logic       touch_edge;
		logic       magnet_pin;
		logic       touch_pin;
		logic [3:0] clear_index;
	} beat_t;

	typedef struct packed {
		logic       touch_over_limit;
		logic       touch_power;
		logic       idle;
		logic [3:0] event_flags;
	} result_t;

endpackage
`default_nettype wire

@@ design/kpc_core.sv @@
// Key press classifier state machine: timers, pending key, flags and touch
// counting, updated once per accepted beat. Depends on kpc_pkg.
`default_nettype none
module kpc_core #(
	parameter int TIMER_BITS = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               step,
	input  kpc_pkg::beat_t    beat,
	input  kpc_pkg::cfg_t     cfg,
	output kpc_pkg::result_t  result
);
	import kpc_pkg::*;

	// compare width wide enough for both timers and 16-bit registers
	localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	phase_t                phase_q, phase_n;
	key_t                  pend_q, pend_n;
	logic                  active_q, active_n;
	logic [7:0]            held_q, held_n;
	logic [TIMER_BITS-1:0] samp_q, samp_n;
	logic [TIMER_BITS-1:0] stuck_q, stuck_n;
	logic [TIMER_BITS-1:0] win_q, win_n;
	logic                  armed_q, armed_n;
	logic [3:0]            flags_q, flags_n;
	logic [15:0]           tpress_q, tpress_n;
	logic                  touch_en_q, touch_en_n;

	// Next-state logic for one tick
	always_comb begin
		logic        due;
		logic        pressed;
		logic        pin;
		logic [7:0]  held_inc;
		logic [15:0] tpress_inc;
		logic        limit_hit;

		samp_n     = (samp_q == '1) ? samp_q : samp_q + 1'b1;
		stuck_n    = (stuck_q == '1) ? stuck_q : stuck_q + 1'b1;
		win_n      = (win_q == '1) ? win_q : win_q + 1'b1;
		pend_n     = pend_q;
		active_n   = active_q;
		held_n     = held_q;
		armed_n    = armed_q;
		flags_n    = flags_q;
		tpress_n   = tpress_q;
		touch_en_n = touch_en_q;
		phase_n    = phase_q;

		// edge strobes, touch wins
		if (beat.touch_edge)
			pend_n = KEY_TOUCH;
		else if (beat.magnet_edge)
			pend_n = KEY_MAGNET;

		// software clear of one flag
		if (beat.clear_index inside {[4'd1:4'd4]})
			flags_n[2'(beat.clear_index - 4'd1)] = 1'b0;

		due = CW'(samp_n) >= CW'(cfg.check_ticks);
		if (phase_q == PH_IDLE && pend_n != KEY_NONE)
			active_n = (pend_n == KEY_TOUCH);
		pin     = active_n ? beat.touch_pin : beat.magnet_pin;
		pressed = (pin == cfg.pressed_level);

		held_inc   = held_q + 8'd1;
		tpress_inc = (tpress_q < TOUCH_CNT_MAX) ? tpress_q + 16'd1 : tpress_q;
		limit_hit  = active_n && (tpress_inc > cfg.touch_limit);

		case (phase_q)
			PH_IDLE: begin
				if (armed_q) begin
					armed_n = 1'b0;
					if (CW'(win_n) < CW'(cfg.window_ticks))
						flags_n[FLAG_WINDOW] = 1'b1;
				end
				if (pend_n != KEY_NONE) begin
					pend_n = KEY_NONE;
					if (pressed) begin
						samp_n  = '0;
						phase_n = PH_SHORT_DEB;
					end
				end else begin
					tpress_n = '0;
				end
			end
			PH_SHORT_DEB, PH_LONG_DEB: begin
				if (due) begin
					if (!pressed) begin
						samp_n  = '0;
						phase_n = (phase_q == PH_SHORT_DEB) ? PH_SHORT_REL : PH_LONG_REL;
					end else begin
						held_n = held_inc;
						if (active_n)
							tpress_n = tpress_inc;
						if ((phase_q == PH_SHORT_DEB) ? (held_inc >= cfg.short_count)
								: (held_inc >= cfg.long_count)) begin
							if (limit_hit) begin
								// touch limit: power off, abort press
								touch_en_n         = 1'b0;
								flags_n[FLAG_ERROR] = 1'b1;
								phase_n            = PH_IDLE;
							end else begin
								samp_n = '0;
								if (phase_q == PH_SHORT_DEB) begin
									flags_n[FLAG_SHORT] = 1'b1;
									phase_n             = PH_LONG_DEB;
								end else begin
									flags_n[FLAG_LONG] = 1'b1;
									armed_n            = 1'b1;
									win_n              = '0;
									phase_n            = PH_LONG_HELD;
								end
							end
						end else begin
							tpress_n = tpress_q;
							samp_n   = '0;
						end
					end
				end
			end
			PH_SHORT_REL, PH_LONG_REL, PH_LONG_HELD_REL: begin
				if (due) begin
					if (!pressed) begin
						held_n = '0;
						if (phase_q == PH_SHORT_REL)
							pend_n = KEY_NONE;
						phase_n = PH_IDLE;
					end else begin
						pend_n  = KEY_NONE;
						samp_n  = '0;
						phase_n = phase_t'(phase_q - 4'd1);
					end
				end
			end
			PH_LONG_HELD: begin
				if (due) begin
					if (!pressed) begin
						samp_n  = '0;
						phase_n = PH_LONG_HELD_REL;
					end else if (!flags_n[FLAG_LONG]) begin
						held_n  = '0;
						stuck_n = '0;
						phase_n = PH_REPEAT_CHK;
					end else begin
						samp_n = '0;
					end
				end
			end
			PH_REPEAT_CHK: begin
				if (CW'(stuck_n) >= CW'(cfg.stuck_ticks)) begin
					held_n              = '0;
					flags_n[FLAG_ERROR] = 1'b1;
					phase_n             = PH_IDLE;
				end else begin
					samp_n  = '0;
					phase_n = PH_REPEAT_DEB;
				end
			end
			PH_REPEAT_DEB: begin
				if (due) begin
					if (!pressed) begin
						samp_n  = '0;
						phase_n = PH_REPEAT_REL;
					end else begin
						held_n = held_inc;
						if (held_inc >= cfg.repeat_count) begin
							held_n             = '0;
							flags_n[FLAG_LONG] = 1'b1;
						end
						phase_n = PH_REPEAT_CHK;
					end
				end
			end
			PH_REPEAT_REL: begin
				if (due) begin
					if (!pressed) begin
						held_n  = '0;
						phase_n = PH_IDLE;
					end else begin
						pend_n  = KEY_NONE;
						phase_n = PH_REPEAT_CHK;
					end
				end
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase
	end

	// Result of the tick, taken from the updated state
	always_comb begin
		result.event_flags      = flags_n;
		result.idle             = (phase_n == PH_IDLE);
		result.touch_power      = touch_en_n;
		result.touch_over_limit = (tpress_n > cfg.touch_limit);
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pend_q     <= KEY_NONE;
			active_q   <= 1'b0;
			held_q     <= '0;
			samp_q     <= '0;
			stuck_q    <= '0;
			win_q      <= '0;
			armed_q    <= 1'b0;
			flags_q    <= '0;
			tpress_q   <= '0;
			touch_en_q <= 1'b1;
		end else if (step) begin
			phase_q    <= phase_n;
			pend_q     <= pend_n;
			active_q   <= active_n;
			held_q     <= held_n;
			samp_q     <= samp_n;
			stuck_q    <= stuck_n;
			win_q      <= win_n;
			armed_q    <= armed_n;
			flags_q    <= flags_n;
			tpress_q   <= tpress_n;
			touch_en_q <= touch_en_n;
		end
	end

	// touch power, once cut, stays off until reset
	a_power_stays_off: assert property (@(posedge clk) disable iff (!arst_n)
		!$rose(touch_en_q)) else $error("touch power came back on");

	// power cut always comes with the error flag
	a_power_cut_flags_error: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(touch_en_q) |-> flags_q[FLAG_ERROR]) else $error("power cut without error");

	// the release window is armed only on entering the long-held phase
	a_window_arm: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(armed_q) |-> phase_q == PH_LONG_HELD) else $error("window armed elsewhere");

	// no state moves without an accepted beat
	a_hold_without_step: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!step) |-> $stable(phase_q) && $stable(flags_q))
		else $error("state changed without a beat");

endmodule
`default_nettype wire

@@ design/kpc_out_buf.sv @@
// Two-entry output buffer (result register plus skid register) for the
// classifier's result stream. No package dependency.
`default_nettype none
module kpc_out_buf #(
	parameter int WIDTH = 8
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire  [WIDTH-1:0] push_data,
	output logic             space,
	output logic             out_valid,
	input  wire              out_ready,
	output logic [WIDTH-1:0] out_data
);
	logic             out_valid_q;
	logic [WIDTH-1:0] out_data_q;
	logic             skid_valid_q;
	logic [WIDTH-1:0] skid_data_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Control: refill the result register from the skid first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	// skid only ever holds a beat behind a waiting result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q) else $error("skid full with result empty");

	// a beat pushed while the skid is full would be lost
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q) else $error("push into full buffer");

	// a stalled result holds on the next edge
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_data_q))
		else $error("stalled result changed");

endmodule
`default_nettype wire

@@ design/key_press_classifier_top.sv @@
// Top level of the key press classifier: stream ports, configuration
// registers, state machine and output buffer. Depends on kpc_pkg, kpc_core
// and kpc_out_buf.
//
// Each input beat is one tick; it yields exactly one result beat. A beat is
// taken every cycle while the output buffer has space: the whole tick update
// (saturating timers, edge latch, flag clear and one machine step) is
// combinational logic in front of the state registers, and the result is
// written on the edge that accepts the beat, into the output register if it
// is free and else into the skid register. A two-entry output buffer keeps
// s_axis_tready high while one result waits; it drops only when two results
// are waiting. Configuration writes are always taken (cfg_ready is tied
// high) and should be made while the block has no result outstanding.
`default_nettype none
module key_press_classifier_top #(
	parameter int TIMER_BITS = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	// input beats
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire  [7:0] s_axis_tdata,  // magnet_edge, touch_edge, magnet_pin, touch_pin,
	                                  // clear_index[3:0]
	// result beats
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata,  // event_flags[3:0], idle, touch_power,
	                                  // touch_over_limit, zero pad
	// configuration writes
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire  [3:0] cfg_index,
	input  wire [15:0] cfg_data
);
	import kpc_pkg::*;

	cfg_t    cfg_q;
	beat_t   beat;
	result_t result;
	logic    accept;
	logic    space;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = space;
	assign accept        = s_axis_tvalid && space;

	// Unpack input beat, first field lowest
	assign beat.magnet_edge = s_axis_tdata[0];
	assign beat.touch_edge  = s_axis_tdata[1];
	assign beat.magnet_pin  = s_axis_tdata[2];
	assign beat.touch_pin   = s_axis_tdata[3];
	assign beat.clear_index = s_axis_tdata[7:4];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_ticks   <= 16'd4;
			cfg_q.short_count   <= 8'd3;
			cfg_q.long_count    <= 8'd100;
			cfg_q.repeat_count  <= 8'd20;
			cfg_q.touch_limit   <= 16'd50;
			cfg_q.stuck_ticks   <= 16'd6000;
			cfg_q.window_ticks  <= 16'd3000;
			cfg_q.pressed_level <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CHECK_TICKS:   cfg_q.check_ticks   <= cfg_data;
				REG_SHORT_COUNT:   cfg_q.short_count   <= cfg_data[7:0];
				REG_LONG_COUNT:    cfg_q.long_count    <= cfg_data[7:0];
				REG_REPEAT_COUNT:  cfg_q.repeat_count  <= cfg_data[7:0];
				REG_TOUCH_LIMIT:   cfg_q.touch_limit   <= cfg_data;
				REG_STUCK_TICKS:   cfg_q.stuck_ticks   <= cfg_data;
				REG_WINDOW_TICKS:  cfg_q.window_ticks  <= cfg_data;
				REG_PRESSED_LEVEL: cfg_q.pressed_level <= cfg_data[0];
				default: ;
			endcase
		end
	end

	kpc_core #(
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.beat   (beat),
		.cfg    (cfg_q),
		.result (result)
	);

	kpc_out_buf #(
		.WIDTH (8)
	) u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data ({1'b0, result}),
		.space     (space),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
`default_nettype wire
